@@ hw/rtl/ovcu_pkg.sv @@
// Shared types, constants, microcode table and arithmetic helpers for the
// oxygen/VEGF cell update core. Has no dependencies of its own.
`timescale 1ns / 1ps

package ovcu_pkg;

  localparam int DataW   = 32;
  localparam int ProdW   = 2 * DataW;
  localparam int DenW    = DataW + 1;
  localparam int SumW    = DataW + 3;
  localparam int CfgIdxW = 4;
  localparam int PcW     = 4;
  localparam int DivCntW = $clog2(DataW);

  localparam bit               Angiogenesis = 1'b1;
  localparam logic [DataW-1:0] StableTol    = DataW'(655);
  localparam logic [DataW-1:0] KmReset      = DataW'(65536);

  typedef enum logic [CfgIdxW-1:0] {
    REG_VMAX_VEGF    = 4'd0,
    REG_KM_VEGF      = 4'd1,
    REG_HYPOXIC_VEGF = 4'd2,
    REG_VMAX_OXYGEN  = 4'd3,
    REG_KM_OXYGEN    = 4'd4,
    REG_OLD_PO2      = 4'd5,
    REG_NEW_PO2      = 4'd6,
    REG_HYP_THRESH   = 4'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_OX_LOAD,
    OP_VG_LOAD,
    OP_PREP,
    OP_DIV,
    OP_OX_UPD,
    OP_VG_UPD
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_OX_SKIP,
    C_VG_SKIP,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  // One control word per step: the step holds while 'hold' is true, then
  // goes to 'target' when 'jump' is true and to the next step otherwise.
  typedef struct packed {
    op_t             op;
    cond_t           hold;
    cond_t           jump;
    logic [PcW-1:0]  target;
  } ctrl_word_t;

  localparam logic [PcW-1:0] StepWait   = PcW'(0);
  localparam logic [PcW-1:0] StepOxLoad = PcW'(1);
  localparam logic [PcW-1:0] StepOxPrep = PcW'(2);
  localparam logic [PcW-1:0] StepOxDiv  = PcW'(3);
  localparam logic [PcW-1:0] StepOxUpd  = PcW'(4);
  localparam logic [PcW-1:0] StepVgLoad = PcW'(5);
  localparam logic [PcW-1:0] StepVgPrep = PcW'(6);
  localparam logic [PcW-1:0] StepVgDiv  = PcW'(7);
  localparam logic [PcW-1:0] StepVgUpd  = PcW'(8);

  function automatic ctrl_word_t ucode_rom(input logic [PcW-1:0] pc);
    ctrl_word_t cw;
    case (pc)
      StepWait:   cw = '{OP_CAPTURE, C_NO_INPUT, C_NEVER,    StepWait};
      StepOxLoad: cw = '{OP_OX_LOAD, C_NEVER,    C_OX_SKIP,  StepOxUpd};
      StepOxPrep: cw = '{OP_PREP,    C_NEVER,    C_NEVER,    StepWait};
      StepOxDiv:  cw = '{OP_DIV,     C_NEVER,    C_DIV_MORE, StepOxDiv};
      StepOxUpd:  cw = '{OP_OX_UPD,  C_NEVER,    C_NEVER,    StepWait};
      StepVgLoad: cw = '{OP_VG_LOAD, C_NEVER,    C_VG_SKIP,  StepVgUpd};
      StepVgPrep: cw = '{OP_PREP,    C_NEVER,    C_NEVER,    StepWait};
      StepVgDiv:  cw = '{OP_DIV,     C_NEVER,    C_DIV_MORE, StepVgDiv};
      StepVgUpd:  cw = '{OP_VG_UPD,  C_OUT_BUSY, C_ALWAYS,   StepWait};
      default:    cw = '{OP_NOP,     C_NEVER,    C_ALWAYS,   StepWait};
    endcase
    return cw;
  endfunction

  // level + incr - cons, formed exactly and clamped to the unsigned range.
  function automatic logic [DataW-1:0] sat_update(input logic [DataW-1:0] level,
                                                  input logic signed [DataW-1:0] incr,
                                                  input logic [DataW-1:0] cons);
    logic signed [SumW-1:0] v;
    v = $signed({3'b000, level}) + SumW'(incr) - $signed({3'b000, cons});
    if (v[SumW-1]) begin
      return '0;
    end else if (v[SumW-2:DataW] != '0) begin
      return '1;
    end else begin
      return v[DataW-1:0];
    end
  endfunction

  function automatic logic is_stable(input logic [DataW-1:0] a,
                                     input logic [DataW-1:0] b);
    logic [DataW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d < StableTol;
  endfunction

endpackage

@@ hw/rtl/oxygen_vegf_cell_update_core.sv @@
// Each cell runs one Michaelis-Menten division in the shared restoring divider, or
// none when the uptake is skipped. One cell is processed at a time: the next input
// is taken once the result is in the output register, which the downstream side
// drains independently.
// Reset (rst, synchronous) returns the sequencer to its wait step, clears the
// result valid and both cell levels, and loads the register defaults.
`timescale 1ns / 1ps

module oxygen_vegf_cell_update_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ovcu_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ovcu_pkg::DataW-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           dead,
  input  logic                           old_vessel,
  input  logic                           new_vessel,
  input  logic signed [ovcu_pkg::DataW-1:0] oxygen_diffusion,
  input  logic signed [ovcu_pkg::DataW-1:0] vegf_diffusion,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ovcu_pkg::DataW-1:0]     oxygen_level,
  output logic [ovcu_pkg::DataW-1:0]     vegf_level,
  output logic                           hypoxic,
  output logic                           oxygen_stable,
  output logic                           vegf_stable
);
  import ovcu_pkg::*;

  // Configuration registers.
  logic [DataW-1:0] vmax_vegf, km_vegf, hypoxic_vegf, vmax_oxygen, km_oxygen;
  logic [DataW-1:0] old_vessel_po2, new_vessel_po2, hypoxia_threshold;

  // Cell state.
  logic [DataW-1:0] oxygen_state, vegf_state;

  // Sequencer and datapath.
  logic [PcW-1:0]     pc, pc_next;
  ctrl_word_t         cw;
  logic [7:0]         cond_vec;
  logic               hold_now, jump_now;
  logic               dead_q, oldv_q, newv_q, hyp_q, ox_stab;
  logic signed [DataW-1:0] dox_q, dvg_q;
  logic [ProdW-1:0]   prod;
  logic [DenW-1:0]    den, den_sum;
  logic [DenW-1:0]    rem;
  logic [DataW-1:0]   quo;
  logic [DivCntW-1:0] cnt;
  logic [DataW-1:0]   ox_new, ox_calc, vg_calc;
  logic [DataW-1:0]   mul_a, mul_b, km_sel;
  logic [DenW:0]      trial;
  logic               trial_ge;
  logic               vessel;

  assign cw        = ucode_rom(pc);
  assign cfg_ready = 1'b1;
  assign in_ready  = (cw.op == OP_CAPTURE);
  assign vessel    = oldv_q | newv_q;

  always_comb begin
    if (cw.op == OP_VG_LOAD) begin
      mul_a  = vegf_state;
      mul_b  = vmax_vegf;
      km_sel = km_vegf;
    end else begin
      mul_a  = oxygen_state;
      mul_b  = vmax_oxygen;
      km_sel = km_oxygen;
    end
    den_sum = {1'b0, km_sel} + {1'b0, mul_a};
  end

  always_comb begin
    cond_vec             = '0;
    cond_vec[C_NEVER]    = 1'b0;
    cond_vec[C_ALWAYS]   = 1'b1;
    cond_vec[C_NO_INPUT] = !in_valid;
    cond_vec[C_OX_SKIP]  = vessel | dead_q | (den_sum == '0);
    cond_vec[C_VG_SKIP]  = !Angiogenesis | !vessel | hyp_q | (den_sum == '0);
    cond_vec[C_DIV_MORE] = (cnt != '1);
    cond_vec[C_OUT_BUSY] = out_valid & !out_ready;
    hold_now = cond_vec[cw.hold];
    jump_now = cond_vec[cw.jump];
    if (hold_now) begin
      pc_next = pc;
    end else if (jump_now) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + PcW'(1);
    end
  end

  // One restoring division step: bring in the next dividend bit and subtract
  // the denominator when it fits.
  always_comb begin
    trial    = {rem, quo[DataW-1]};
    trial_ge = (trial >= {1'b0, den});
  end

  always_comb begin
    if (oldv_q) begin
      ox_calc = old_vessel_po2;
    end else if (newv_q) begin
      ox_calc = new_vessel_po2;
    end else begin
      ox_calc = sat_update(oxygen_state, dox_q, quo);
    end
    if (!Angiogenesis) begin
      vg_calc = vegf_state;
    end else if (hyp_q) begin
      vg_calc = hypoxic_vegf;
    end else begin
      vg_calc = sat_update(vegf_state, dvg_q, quo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc                <= StepWait;
      out_valid         <= 1'b0;
      oxygen_state      <= '0;
      vegf_state        <= '0;
      vmax_vegf         <= '0;
      km_vegf           <= KmReset;
      hypoxic_vegf      <= '0;
      vmax_oxygen       <= '0;
      km_oxygen         <= KmReset;
      old_vessel_po2    <= '0;
      new_vessel_po2    <= '0;
      hypoxia_threshold <= '0;
    end else begin
      pc <= pc_next;

      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_VMAX_VEGF:    vmax_vegf         <= cfg_data;
          REG_KM_VEGF:      km_vegf           <= cfg_data;
          REG_HYPOXIC_VEGF: hypoxic_vegf      <= cfg_data;
          REG_VMAX_OXYGEN:  vmax_oxygen       <= cfg_data;
          REG_KM_OXYGEN:    km_oxygen         <= cfg_data;
          REG_OLD_PO2:      old_vessel_po2    <= cfg_data;
          REG_NEW_PO2:      new_vessel_po2    <= cfg_data;
          REG_HYP_THRESH:   hypoxia_threshold <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cw.op == OP_VG_UPD && !hold_now) begin
        out_valid    <= 1'b1;
        oxygen_state <= ox_new;
        vegf_state   <= vg_calc;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_CAPTURE: begin
        if (!hold_now) begin
          dead_q <= dead;
          oldv_q <= old_vessel;
          newv_q <= new_vessel;
          dox_q  <= oxygen_diffusion;
          dvg_q  <= vegf_diffusion;
        end
      end
      OP_OX_LOAD, OP_VG_LOAD: begin
        prod <= ProdW'(mul_a) * ProdW'(mul_b);
        den  <= den_sum;
        quo  <= '0;
      end
      OP_PREP: begin
        // The quotient never exceeds vmax, so the upper half is below den.
        rem <= {1'b0, prod[ProdW-1:DataW]};
        quo <= prod[DataW-1:0];
        cnt <= '0;
      end
      OP_DIV: begin
        rem <= trial_ge ? DenW'(trial - {1'b0, den}) : trial[DenW-1:0];
        quo <= {quo[DataW-2:0], trial_ge};
        cnt <= cnt + DivCntW'(1);
      end
      OP_OX_UPD: begin
        ox_new  <= ox_calc;
        ox_stab <= is_stable(ox_calc, oxygen_state);
        hyp_q   <= !dead_q && (ox_calc < hypoxia_threshold);
      end
      OP_VG_UPD: begin
        if (!hold_now) begin
          oxygen_level  <= ox_new;
          vegf_level    <= vg_calc;
          hypoxic       <= hyp_q;
          oxygen_stable <= ox_stab;
          vegf_stable   <= is_stable(vg_calc, vegf_state);
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/ovcu_checker.sv @@
// Port-level checker for the oxygen/VEGF cell update core, bound to the top
// level below. Depends on ovcu_pkg for the level width.
`timescale 1ns / 1ps

module ovcu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ovcu_pkg::DataW-1:0] oxygen_level,
  input logic [ovcu_pkg::DataW-1:0] vegf_level,
  input logic                       hypoxic,
  input logic                       oxygen_stable,
  input logic                       vegf_stable
);
  import ovcu_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(oxygen_level) &&
      $stable(vegf_level) && $stable({hypoxic, oxygen_stable, vegf_stable}))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Cells are processed one at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second input transaction taken while a cell is in flight");

  // A new result only appears from the final step, never from the wait step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the core was waiting for input");

endmodule

bind oxygen_vegf_cell_update_core ovcu_checker u_ovcu_checker (.*);

@@ sim/ovcu_level_check.sv @@
// Passive checker for the oxygen/VEGF cell update core: tracks register writes,
// predicts each cell result and compares it with what the core delivers.
// Depends on ovcu_pkg for widths, register indexes and the stability tolerance.
`timescale 1ns / 1ps

module ovcu_level_check (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [ovcu_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [ovcu_pkg::DataW-1:0]        cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              dead,
  input  logic                              old_vessel,
  input  logic                              new_vessel,
  input  logic signed [ovcu_pkg::DataW-1:0] oxygen_diffusion,
  input  logic signed [ovcu_pkg::DataW-1:0] vegf_diffusion,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [ovcu_pkg::DataW-1:0]        oxygen_level,
  input  logic [ovcu_pkg::DataW-1:0]        vegf_level,
  input  logic                              hypoxic,
  input  logic                              oxygen_stable,
  input  logic                              vegf_stable,
  output int                                fail_count,
  output int                                outstanding
);
  import ovcu_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] oxygen_level;
    logic [DataW-1:0] vegf_level;
    logic             hypoxic;
    logic             oxygen_stable;
    logic             vegf_stable;
  } cell_result_t;

  logic [DataW-1:0] vmax_vg, km_vg, hyp_vg, vmax_ox, km_ox, old_po2, new_po2, hyp_thr;
  logic [DataW-1:0] ox_prev, vg_prev;
  cell_result_t     expected_cells[$];
  int               cells_seen;

  // Michaelis-Menten uptake: level*vmax / (km+level), with a 33-bit denominator.
  function automatic logic [DataW-1:0] mm_uptake(input logic [DataW-1:0] level, vmax, km);
    logic [DenW-1:0]  den;
    logic [ProdW-1:0] num;
    den = {1'b0, km} + {1'b0, level};
    num = ProdW'(level) * ProdW'(vmax);
    if (den == '0) return '0;
    return DataW'(num / ProdW'(den));
  endfunction

  function automatic logic [DataW-1:0] clamp_level(input logic [DataW-1:0] level,
                                                   input logic signed [DataW-1:0] incr,
                                                   input logic [DataW-1:0] cons);
    longint v;
    v = longint'({32'b0, level}) + longint'(incr) - longint'({32'b0, cons});
    if (v < 0) return '0;
    if (v > longint'(64'hFFFF_FFFF)) return '1;
    return v[DataW-1:0];
  endfunction

  function automatic logic near(input logic [DataW-1:0] a, b);
    logic [DataW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d < StableTol;
  endfunction

  function automatic cell_result_t advance_cell(input logic is_dead, is_old, is_new,
                                                input logic signed [DataW-1:0] dox, dvg);
    cell_result_t r;
    if (is_old) begin
      r.oxygen_level = old_po2;
    end else if (is_new) begin
      r.oxygen_level = new_po2;
    end else begin
      r.oxygen_level = clamp_level(ox_prev, dox,
                                   is_dead ? '0 : mm_uptake(ox_prev, vmax_ox, km_ox));
    end
    r.hypoxic = !is_dead && (r.oxygen_level < hyp_thr);
    r.vegf_level = vg_prev;
    if (Angiogenesis) begin
      if (r.hypoxic) begin
        r.vegf_level = hyp_vg;
      end else begin
        // Only vessel cells take up VEGF.
        r.vegf_level = clamp_level(vg_prev, dvg,
                                   (is_old || is_new) ? mm_uptake(vg_prev, vmax_vg, km_vg)
                                                      : '0);
      end
    end
    r.oxygen_stable = near(r.oxygen_level, ox_prev);
    r.vegf_stable   = near(r.vegf_level, vg_prev);
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin : track
    cell_result_t got;
    cell_result_t want;
    if (rst) begin
      vmax_vg = '0;
      km_vg   = KmReset;
      hyp_vg  = '0;
      vmax_ox = '0;
      km_ox   = KmReset;
      old_po2 = '0;
      new_po2 = '0;
      hyp_thr = '0;
      ox_prev = '0;
      vg_prev = '0;
      expected_cells.delete();
      cells_seen = 0;
      fail_count = 0;
    end else begin
      // Results first: a cell accepted at this edge cannot already have its result.
      if (out_valid && out_ready) begin
        got = '{oxygen_level, vegf_level, hypoxic, oxygen_stable, vegf_stable};
        if (expected_cells.size() == 0) begin
          note_failure($sformatf("result with no cell pending: ox=%h vegf=%h hyp=%b",
                                 got.oxygen_level, got.vegf_level, got.hypoxic));
        end else begin
          want = expected_cells.pop_front();
          if (got.oxygen_level !== want.oxygen_level || got.vegf_level !== want.vegf_level ||
              got.hypoxic !== want.hypoxic || got.oxygen_stable !== want.oxygen_stable ||
              got.vegf_stable !== want.vegf_stable) begin
            note_failure($sformatf({"cell %0d: expected ox=%h vegf=%h hyp=%b ox_st=%b ",
                                    "vegf_st=%b, got ox=%h vegf=%h hyp=%b ox_st=%b vegf_st=%b"},
                                   cells_seen, want.oxygen_level, want.vegf_level,
                                   want.hypoxic, want.oxygen_stable, want.vegf_stable,
                                   got.oxygen_level, got.vegf_level, got.hypoxic,
                                   got.oxygen_stable, got.vegf_stable));
          end
        end
        cells_seen++;
      end
      if (in_valid && in_ready) begin
        want = advance_cell(dead, old_vessel, new_vessel, oxygen_diffusion, vegf_diffusion);
        expected_cells = {expected_cells, want};
        ox_prev = want.oxygen_level;
        vg_prev = want.vegf_level;
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_VMAX_VEGF:    vmax_vg = cfg_data;
          REG_KM_VEGF:      km_vg   = cfg_data;
          REG_HYPOXIC_VEGF: hyp_vg  = cfg_data;
          REG_VMAX_OXYGEN:  vmax_ox = cfg_data;
          REG_KM_OXYGEN:    km_ox   = cfg_data;
          REG_OLD_PO2:      old_po2 = cfg_data;
          REG_NEW_PO2:      new_po2 = cfg_data;
          REG_HYP_THRESH:   hyp_thr = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = expected_cells.size();
  end

endmodule

@@ sim/tb_oxygen_vegf_cell_update_core.sv @@
// Top-level testbench for oxygen_vegf_cell_update_core: drives register writes
// and cell transactions with random idling, and reports the verdict.
// Depends on ovcu_pkg, the core itself and the ovcu_level_check checker.
`timescale 1ns / 1ps

module tb_oxygen_vegf_cell_update_core;
  import ovcu_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIdxW-1:0]      cfg_index = '0;
  logic [DataW-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    dead = 1'b0;
  logic                    old_vessel = 1'b0;
  logic                    new_vessel = 1'b0;
  logic signed [DataW-1:0] oxygen_diffusion = '0;
  logic signed [DataW-1:0] vegf_diffusion = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [DataW-1:0]        oxygen_level;
  logic [DataW-1:0]        vegf_level;
  logic                    hypoxic;
  logic                    oxygen_stable;
  logic                    vegf_stable;

  int fail_count;
  int outstanding;
  int in_idle_pct = 0;
  int out_idle_pct = 0;

  oxygen_vegf_cell_update_core DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .dead(dead), .old_vessel(old_vessel), .new_vessel(new_vessel),
    .oxygen_diffusion(oxygen_diffusion), .vegf_diffusion(vegf_diffusion),
    .out_valid(out_valid), .out_ready(out_ready),
    .oxygen_level(oxygen_level), .vegf_level(vegf_level), .hypoxic(hypoxic),
    .oxygen_stable(oxygen_stable), .vegf_stable(vegf_stable)
  );

  ovcu_level_check level_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .dead(dead), .old_vessel(old_vessel), .new_vessel(new_vessel),
    .oxygen_diffusion(oxygen_diffusion), .vegf_diffusion(vegf_diffusion),
    .out_valid(out_valid), .out_ready(out_ready),
    .oxygen_level(oxygen_level), .vegf_level(vegf_level), .hypoxic(hypoxic),
    .oxygen_stable(oxygen_stable), .vegf_stable(vegf_stable),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** oxygen_vegf_cell_update_core: FAILED **");
    $finish;
  end

  // Downstream stalls come in bursts, each started with a chance of out_idle_pct percent.
  initial begin : drain
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        burst--;
        out_ready = 1'b0;
      end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
        burst = $urandom_range(0, 7);
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // All tasks below start and end just after a falling edge.
  task automatic send_cell(input logic d, ov, nv, input logic signed [DataW-1:0] dox, dvg);
    if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    dead = d;
    old_vessel = ov;
    new_vessel = nv;
    oxygen_diffusion = dox;
    vegf_diffusion = dvg;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DataW-1:0] value);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain_cells();
    while (outstanding != 0) @(negedge clk);
  endtask

  // Registers are only rewritten once every pending cell has come out.
  task automatic set_rates(input logic [DataW-1:0] vmax_vg, km_vg, hyp_vg, vmax_ox,
                           km_ox, old_po2, new_po2, hyp_thr);
    drain_cells();
    write_reg(REG_VMAX_VEGF, vmax_vg);
    write_reg(REG_KM_VEGF, km_vg);
    write_reg(REG_HYPOXIC_VEGF, hyp_vg);
    write_reg(REG_VMAX_OXYGEN, vmax_ox);
    write_reg(REG_KM_OXYGEN, km_ox);
    write_reg(REG_OLD_PO2, old_po2);
    write_reg(REG_NEW_PO2, new_po2);
    write_reg(REG_HYP_THRESH, hyp_thr);
  endtask

  function automatic logic [DataW-1:0] pick_rate();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h0001_0000;
      3:       return 32'd1;
      4, 5:    return $urandom_range(0, 32'h0008_0000);
      default: return $urandom;
    endcase
  endfunction

  // Mostly small and medium increments, so levels hover and stability flags toggle.
  function automatic logic signed [DataW-1:0] pick_step();
    int s;
    case ($urandom_range(0, 5))
      0, 1:    s = int'($urandom_range(0, 2000)) - 1000;
      2, 3:    s = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      4:       s = $urandom;
      default: s = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
    return s;
  endfunction

  initial begin : stimulus
    int   r;
    logic d, ov, nv;

    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Default registers: no uptake, threshold zero, so never hypoxic.
    send_cell(1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0);
    send_cell(1'b0, 1'b0, 1'b0, 32'sd654, 32'sd655);
    send_cell(1'b1, 1'b0, 1'b0, -32'sd655, -32'sd654);
    send_cell(1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_cell(1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_cell(1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_cell(1'b0, 1'b1, 1'b0, 32'h8000_0000, 32'h8000_0000);
    send_cell(1'b0, 1'b0, 1'b0, 32'h8000_0000, 32'h8000_0000);
    send_cell(1'b0, 1'b0, 1'b0, 32'h8000_0000, 32'h8000_0000);
    send_cell(1'b0, 1'b0, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA);

    // Extreme registers: maximum uptake rates with zero Michaelis constants.
    set_rates('1, '0, '1, '1, '0, '1, '0, 32'h0001_0000);
    send_cell(1'b0, 1'b0, 1'b0, 32'h8000_0000, 32'h8000_0000);
    send_cell(1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0);
    send_cell(1'b0, 1'b0, 1'b0, 32'h4000_0000, 32'sd0);
    send_cell(1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0);
    send_cell(1'b0, 1'b1, 1'b0, 32'sd0, 32'h8000_0000);
    send_cell(1'b0, 1'b1, 1'b1, 32'sd0, 32'sd0);
    send_cell(1'b0, 1'b0, 1'b1, 32'sd0, 32'h7FFF_FFFF);
    send_cell(1'b1, 1'b0, 1'b1, 32'sd0, 32'sd0);
    send_cell(1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'sd0);
    send_cell(1'b1, 1'b0, 1'b0, 32'sd0, 32'sd0);
    send_cell(1'b0, 1'b0, 1'b0, 32'h0000_FFFF, 32'sd1);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       begin in_idle_pct = 20; out_idle_pct = 20; end
        1:       begin in_idle_pct = 0;  out_idle_pct = 0;  end
        2:       begin in_idle_pct = 50; out_idle_pct = 10; end
        3:       begin in_idle_pct = 10; out_idle_pct = 50; end
        4:       begin in_idle_pct = 30; out_idle_pct = 30; end
        default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
      endcase
      if (phase == 0 || phase == 3) begin
        set_rates(32'h0000_8000, 32'h0001_0000, 32'h0005_0000, 32'h0002_0000,
                  32'h0003_0000, 32'h0050_0000, 32'h0040_0000, 32'h0008_0000);
      end else begin
        set_rates(pick_rate(), pick_rate(), pick_rate(), pick_rate(),
                  pick_rate(), pick_rate(), pick_rate(), pick_rate());
      end
      repeat (100) begin
        r  = $urandom_range(0, 99);
        d  = ($urandom_range(0, 4) == 0);
        ov = (r >= 80 && r < 90) || r >= 97;
        nv = r >= 90;
        send_cell(d, ov, nv, pick_step(), pick_step());
      end
    end

    drain_cells();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** oxygen_vegf_cell_update_core: PASSED **");
    end else begin
      $display("** oxygen_vegf_cell_update_core: FAILED **");
    end
    $finish;
  end

endmodule
